// ----- rtl/core/jsc_pkg.sv -----
// Shared types, constants and helper functions of the JSON syntax checker.
package jsc_pkg;

	// Stack sizing
	localparam int MAX_DEPTH = 64;
	localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	// Verdict codes
	localparam logic [1:0] V_PENDING = 2'd0;
	localparam logic [1:0] V_VALID   = 2'd1;
	localparam logic [1:0] V_ERROR   = 2'd2;
	localparam logic [1:0] V_DEEP    = 2'd3;

	// Literal kinds
	localparam logic [1:0] LIT_TRUE  = 2'd0;
	localparam logic [1:0] LIT_FALSE = 2'd1;
	localparam logic [1:0] LIT_NULL  = 2'd2;

	// Parser modes, one-hot
	typedef enum logic [11:0] {
		M_FIRST     = 12'b0000_0000_0001,
		M_VALUE     = 12'b0000_0000_0010,
		M_ARR_FIRST = 12'b0000_0000_0100,
		M_OBJ_FIRST = 12'b0000_0000_1000,
		M_KEY       = 12'b0000_0001_0000,
		M_STRING    = 12'b0000_0010_0000,
		M_COLON     = 12'b0000_0100_0000,
		M_SIGN      = 12'b0000_1000_0000,
		M_DIGITS    = 12'b0001_0000_0000,
		M_LITERAL   = 12'b0010_0000_0000,
		M_AFTER     = 12'b0100_0000_0000,
		M_DONE      = 12'b1000_0000_0000
	} mode_t;

	// Per-document parser state
	typedef struct packed {
		mode_t             mode;
		logic [LVL_W-1:0]  level;
		logic [1:0]        kind;
		logic [2:0]        pos;
		logic              esc;
		logic              key;
		logic [1:0]        held;
	} state_t;

	// Stack operation for one transfer
	typedef struct packed {
		logic en;
		logic push;
		logic pop;
		logic obj;
	} stk_ctrl_t;

	function automatic logic is_space(input logic [7:0] c);
		return c inside {8'h20, 8'h0D, 8'h0A, 8'h09};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	// Length of each literal word
	function automatic logic [2:0] lit_len(input logic [1:0] kind);
		logic [2:0] len;
		case (kind)
			LIT_TRUE:  len = 3'd4;
			LIT_FALSE: len = 3'd5;
			LIT_NULL:  len = 3'd4;
			default:   len = 3'd0;
		endcase
		return len;
	endfunction

	// Character of a literal word at a position
	function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		case (kind)
			LIT_TRUE: begin
				case (pos)
					3'd0:    ch = "t";
					3'd1:    ch = "r";
					3'd2:    ch = "u";
					3'd3:    ch = "e";
					default: ch = 8'h00;
				endcase
			end
			LIT_FALSE: begin
				case (pos)
					3'd0:    ch = "f";
					3'd1:    ch = "a";
					3'd2:    ch = "l";
					3'd3:    ch = "s";
					3'd4:    ch = "e";
					default: ch = 8'h00;
				endcase
			end
			LIT_NULL: begin
				case (pos)
					3'd0:    ch = "n";
					3'd1:    ch = "u";
					3'd2:    ch = "l";
					3'd3:    ch = "l";
					default: ch = 8'h00;
				endcase
			end
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Value complete: final at top level, otherwise wait for a separator
	function automatic state_t value_done(input state_t s);
		state_t n;
		n = s;
		if (s.level == '0) begin
			n.held = V_VALID;
			n.mode = M_DONE;
		end else begin
			n.mode = M_AFTER;
		end
		return n;
	endfunction

endpackage

// ----- rtl/core/jsc_step.sv -----
// Next-state and verdict logic for one byte of text.
module jsc_step (
	input  jsc_pkg::state_t           st,
	input  logic                      top_obj,
	input  logic [7:0]                c,
	input  logic                      last,
	output jsc_pkg::state_t           st_next,
	output jsc_pkg::stk_ctrl_t        stk,
	output logic [1:0]                verdict,
	output logic [6:0]                depth,
	output logic                      doc_end
);

	jsc_pkg::state_t n;
	logic            obj;
	logic            do_start;
	logic            do_after;
	logic            do_close;
	logic            ended;

	always_comb begin
		n        = st;
		stk      = '0;
		do_start = 1'b0;
		do_after = 1'b0;
		do_close = 1'b0;
		obj      = (st.level != '0) ? top_obj : 1'b0;

		// Per-mode handling of the byte
		case (st.mode)
			jsc_pkg::M_FIRST, jsc_pkg::M_VALUE: begin
				do_start = !jsc_pkg::is_space(c);
			end
			jsc_pkg::M_ARR_FIRST: begin
				if (c == "]")
					do_close = 1'b1;
				else
					do_start = !jsc_pkg::is_space(c);
			end
			jsc_pkg::M_OBJ_FIRST, jsc_pkg::M_KEY: begin
				if (!jsc_pkg::is_space(c)) begin
					if (c == "}" && st.mode == jsc_pkg::M_OBJ_FIRST) begin
						do_close = 1'b1;
					end else if (c == "\"") begin
						n.mode = jsc_pkg::M_STRING;
						n.key  = 1'b1;
						n.esc  = 1'b0;
					end else begin
						n.held = jsc_pkg::V_ERROR;
						n.mode = jsc_pkg::M_DONE;
					end
				end
			end
			jsc_pkg::M_STRING: begin
				if (st.esc)
					n.esc = 1'b0;
				else if (c == "\\")
					n.esc = 1'b1;
				else if (c == "\"") begin
					if (st.key)
						n.mode = jsc_pkg::M_COLON;
					else
						n = jsc_pkg::value_done(st);
				end
			end
			jsc_pkg::M_COLON: begin
				if (c == ":")
					n.mode = jsc_pkg::M_VALUE;
				else if (!jsc_pkg::is_space(c)) begin
					n.held = jsc_pkg::V_ERROR;
					n.mode = jsc_pkg::M_DONE;
				end
			end
			jsc_pkg::M_SIGN: begin
				if (jsc_pkg::is_digit(c))
					n.mode = jsc_pkg::M_DIGITS;
				else begin
					n.held = jsc_pkg::V_ERROR;
					n.mode = jsc_pkg::M_DONE;
				end
			end
			jsc_pkg::M_DIGITS: begin
				if (!jsc_pkg::is_digit(c)) begin
					if (st.level == '0) begin
						n.held = jsc_pkg::V_VALID;
						n.mode = jsc_pkg::M_DONE;
					end else begin
						n.mode   = jsc_pkg::M_AFTER;
						do_after = 1'b1;
					end
				end
			end
			jsc_pkg::M_LITERAL: begin
				if (st.pos >= jsc_pkg::lit_len(st.kind) ||
				    jsc_pkg::lit_char(st.kind, st.pos) != c) begin
					n.held = jsc_pkg::V_ERROR;
					n.mode = jsc_pkg::M_DONE;
				end else begin
					n.pos = st.pos + 3'd1;
					if (n.pos >= jsc_pkg::lit_len(st.kind))
						n = jsc_pkg::value_done(n);
				end
			end
			jsc_pkg::M_AFTER: begin
				do_after = 1'b1;
			end
			jsc_pkg::M_DONE: begin
				n = st;
			end
			default: begin
				n.held = jsc_pkg::V_ERROR;
				n.mode = jsc_pkg::M_DONE;
			end
		endcase

		// Start of a value
		if (do_start) begin
			if (c == "{" || c == "[") begin
				if (st.level >= jsc_pkg::LVL_W'(jsc_pkg::MAX_DEPTH)) begin
					n.held = jsc_pkg::V_DEEP;
					n.mode = jsc_pkg::M_DONE;
				end else begin
					stk.push = 1'b1;
					stk.obj  = (c == "{");
					n.level  = st.level + jsc_pkg::LVL_W'(1);
					n.mode   = (c == "{") ? jsc_pkg::M_OBJ_FIRST : jsc_pkg::M_ARR_FIRST;
				end
			end else if (c == "\"") begin
				n.mode = jsc_pkg::M_STRING;
				n.key  = 1'b0;
				n.esc  = 1'b0;
			end else if (c == "t" || c == "f" || c == "n") begin
				n.kind = (c == "t") ? jsc_pkg::LIT_TRUE :
				         ((c == "f") ? jsc_pkg::LIT_FALSE : jsc_pkg::LIT_NULL);
				n.pos  = 3'd1;
				n.mode = jsc_pkg::M_LITERAL;
			end else if (c == "-") begin
				n.mode = jsc_pkg::M_SIGN;
			end else if (jsc_pkg::is_digit(c)) begin
				n.mode = jsc_pkg::M_DIGITS;
			end else begin
				n.held = jsc_pkg::V_ERROR;
				n.mode = jsc_pkg::M_DONE;
			end
		end

		// Separator or closer after a value
		if (do_after && !jsc_pkg::is_space(c)) begin
			if (c == ",")
				n.mode = obj ? jsc_pkg::M_KEY : jsc_pkg::M_VALUE;
			else if ((c == "}" && obj) || (c == "]" && !obj))
				do_close = 1'b1;
			else begin
				n.held = jsc_pkg::V_ERROR;
				n.mode = jsc_pkg::M_DONE;
			end
		end

		// Close the innermost container
		if (do_close) begin
			if (st.level != '0) begin
				stk.pop = 1'b1;
				n.level = st.level - jsc_pkg::LVL_W'(1);
			end
			n = jsc_pkg::value_done(n);
		end

		// Text ran out before the verdict was settled
		if (last && n.mode != jsc_pkg::M_DONE) begin
			n.held = (n.mode == jsc_pkg::M_DIGITS && n.level == '0) ?
			         jsc_pkg::V_VALID : jsc_pkg::V_ERROR;
			n.mode = jsc_pkg::M_DONE;
		end

		ended   = (n.mode == jsc_pkg::M_DONE);
		verdict = ended ? n.held : jsc_pkg::V_PENDING;
		depth   = 7'(n.level);
		doc_end = ended;

		// Fresh document after the last byte
		st_next = n;
		if (last) begin
			st_next.mode  = jsc_pkg::M_FIRST;
			st_next.level = '0;
			st_next.kind  = 2'd0;
			st_next.pos   = 3'd0;
			st_next.esc   = 1'b0;
			st_next.key   = 1'b0;
			st_next.held  = jsc_pkg::V_PENDING;
		end
	end

endmodule

// ----- rtl/core/jsc_stack.sv -----
// Container stack: top entry in a register, lower entries in a memory with prefetch.
module jsc_stack (
	input  logic                         clk,
	input  logic                         arst_n,
	input  jsc_pkg::stk_ctrl_t           ctrl,
	input  logic [jsc_pkg::LVL_W-1:0]    level_q,
	input  logic [jsc_pkg::LVL_W-1:0]    level_next,
	output logic                         top_obj
);

	logic                      mem [jsc_pkg::MAX_DEPTH];
	logic                      top_q;
	logic                      below_q;
	logic                      wr_en;
	logic [jsc_pkg::LVL_W-1:0] wr_lvl;
	logic [jsc_pkg::LVL_W-1:0] rd_lvl;
	logic [jsc_pkg::IDX_W-1:0] wr_addr;
	logic [jsc_pkg::IDX_W-1:0] rd_addr;

	// Push spills the old top into the memory; prefetch the entry under the new top
	always_comb begin
		wr_en   = ctrl.en && ctrl.push && (level_q != '0);
		wr_lvl  = level_q - jsc_pkg::LVL_W'(1);
		rd_lvl  = level_next - jsc_pkg::LVL_W'(2);
		wr_addr = wr_lvl[jsc_pkg::IDX_W-1:0];
		rd_addr = rd_lvl[jsc_pkg::IDX_W-1:0];
	end

	// Memory write and registered read with write forwarding
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= top_q;
		if (ctrl.en)
			below_q <= (wr_en && wr_addr == rd_addr) ? top_q : mem[rd_addr];
	end

	// Top of stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			top_q <= 1'b0;
		else if (ctrl.en) begin
			if (ctrl.push)
				top_q <= ctrl.obj;
			else if (ctrl.pop)
				top_q <= below_q;
		end
	end

	assign top_obj = top_q;

endmodule

// ----- rtl/core/json_syntax_checker.sv -----
// Top level of the JSON syntax checker: input register, parser state, result register.
//
// Checks a JSON text arriving one byte per transfer and returns one result per byte: the
// running verdict, the open object/array depth and a final-verdict flag. A byte is taken in
// every cycle while in_stall is low; its result passes from the input register to the result
// register and can be taken while the output is not stalled. The rate is set by the parser
// state update, which keeps the top of the container stack in a register and prefetches the
// entry below it from the stack memory (64 entries, one write and one read port).
// end_of_text closes the document and the next byte starts a new one. No clearing pass is
// needed after reset.
module json_syntax_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] verdict,
	output logic [6:0] nesting_depth,
	output logic       document_end
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic                advance;
	jsc_pkg::state_t     state_q;
	jsc_pkg::state_t     state_next;
	jsc_pkg::stk_ctrl_t  stk_op;
	jsc_pkg::stk_ctrl_t  stk_ctrl;
	logic                top_obj;
	logic [1:0]          verdict_nx;
	logic [6:0]          depth_nx;
	logic                doc_end_nx;
	logic                out_valid_s2;
	logic [1:0]          verdict_s2;
	logic [6:0]          depth_s2;
	logic                doc_end_s2;

	// Byte moves to the result register when that register is free or draining
	assign advance  = valid_s1 && (!out_valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && !in_stall)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
			last_s1 <= end_of_text;
		end
	end

	jsc_step u_step (
		.st      (state_q),
		.top_obj (top_obj),
		.c       (byte_s1),
		.last    (last_s1),
		.st_next (state_next),
		.stk     (stk_op),
		.verdict (verdict_nx),
		.depth   (depth_nx),
		.doc_end (doc_end_nx)
	);

	always_comb begin
		stk_ctrl    = stk_op;
		stk_ctrl.en = advance;
	end

	jsc_stack u_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (stk_ctrl),
		.level_q    (state_q.level),
		.level_next (state_next.level),
		.top_obj    (top_obj)
	);

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode  <= jsc_pkg::M_FIRST;
			state_q.level <= '0;
			state_q.kind  <= 2'd0;
			state_q.pos   <= 3'd0;
			state_q.esc   <= 1'b0;
			state_q.key   <= 1'b0;
			state_q.held  <= jsc_pkg::V_PENDING;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_s2 <= 1'b0;
		else if (advance)
			out_valid_s2 <= 1'b1;
		else if (!out_stall)
			out_valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_s2 <= verdict_nx;
			depth_s2   <= depth_nx;
			doc_end_s2 <= doc_end_nx;
		end
	end

	assign out_valid     = out_valid_s2;
	assign verdict       = verdict_s2;
	assign nesting_depth = depth_s2;
	assign document_end  = doc_end_s2;

endmodule
